// ----- rtl/core/pti_pkg.sv -----
// shared types and constants for the periodic table interpolator
package pti_pkg;

  localparam int MAX_POINTS_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int DATA_W         = 32;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FEW      = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_ZERO_PER = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMD,
    S_RD_FIRST,
    S_RD_LAST,
    S_REM,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_LASTQ,
    S_QL,
    S_QR,
    S_DIV,
    S_MUL,
    S_FIN,
    S_OUT
  } state_t;

endpackage

// ----- rtl/core/pti_ram.sv -----
// generic single write port ram with registered read
module pti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/pti_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module pti_div #(
  parameter int DW = 49
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [32:0]   divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [32:0]   remainder
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [33:0]      rem_r, rem_nxt;
  logic [DW-1:0]    quo_r, quo_nxt;
  logic [32:0]      dvs_r, dvs_nxt;
  logic [33:0]      sh;
  logic             fits;

  always_comb begin
    sh       = {rem_r[32:0], quo_r[DW-1]};
    fits     = (sh >= {1'b0, dvs_r});
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      cnt_nxt = CNT_W'(DW);
      run_nxt = 1'b1;
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (run_r) begin
      rem_nxt = fits ? (sh - {1'b0, dvs_r}) : sh;
      quo_nxt = {quo_r[DW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r[32:0];

endmodule

// ----- rtl/core/periodic_table_interpolator.sv -----
// periodic piecewise linear interpolator over a breakpoint table
// Commands are taken when start is high and busy is low; exactly one result follows, shown
// for one cycle with out_valid high, and it cannot be held off. One shared restoring divider
// does the time wrap remainder and then the interpolation fraction at one bit per cycle,
// and the interval search reads the time memory, which has one registered read port, one
// breakpoint at a time. Errors finish early.
module periodic_table_interpolator
  import pti_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_cmd,
  input  logic signed [DATA_W-1:0] in_sample_time,
  input  logic signed [DATA_W-1:0] in_flow_value,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_interp_value,
  output logic [1:0]               out_status
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DW = 33 + FRAC_BITS;
  localparam int PW = 35 + FRAC_BITS;
  localparam int AL = FRAC_BITS + 1;
  localparam logic [AL-1:0] SCALE = AL'(1) << FRAC_BITS;

  state_t state_r, state_nxt;

  logic [1:0]               cmd_r, cmd_nxt;
  logic signed [DATA_W-1:0] t_r, t_nxt;
  logic signed [DATA_W-1:0] q_r, q_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic signed [DATA_W-1:0] t0_r, t0_nxt;
  logic signed [DATA_W-1:0] tw_r, tw_nxt;
  logic signed [DATA_W-1:0] tl_r, tl_nxt;
  logic signed [DATA_W-1:0] tr_r, tr_nxt;
  logic signed [DATA_W-1:0] ql_r, ql_nxt;
  logic signed [DATA_W-1:0] qr_r, qr_nxt;
  logic [32:0]              period_r, period_nxt;
  logic                     neg_r, neg_nxt;
  logic [AL-1:0]            alpha_r, alpha_nxt;
  logic signed [PW-1:0]     prod_r, prod_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic [1:0]               stat_r, stat_nxt;

  // memory and divider hookup
  logic              wr_en;
  logic [AW-1:0]     t_raddr, f_raddr;
  logic [DATA_W-1:0] t_rdata, f_rdata;
  logic              div_start, div_done;
  logic [DW-1:0]     div_dividend, div_quo;
  logic [32:0]       div_divisor, div_rem;

  // datapath helpers
  logic signed [32:0]   per_w, d_w, num_w, dt_w, r_w, twide_w;
  logic [32:0]          d_mag, num_mag, dt_mag;
  logic                 more_pts;
  logic signed [32:0]   diff_w;
  logic signed [PW-1:0] mul_w, sh_w, sum_w;

  pti_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_time_ram (
    .clk(clk), .we(wr_en), .waddr(count_r[AW-1:0]), .wdata(t_r),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  pti_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_flow_ram (
    .clk(clk), .we(wr_en), .waddr(count_r[AW-1:0]), .wdata(q_r),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  pti_div #(.DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(div_quo), .remainder(div_rem)
  );

  always_comb begin
    per_w    = 33'(signed'(t_rdata)) - 33'(t0_r);
    d_w      = 33'(t_r) - 33'(t0_r);
    d_mag    = d_w[32] ? 33'(-d_w) : d_w;
    r_w      = (neg_r && (div_rem != '0)) ? signed'(period_r - div_rem) : signed'(div_rem);
    twide_w  = r_w + 33'(t0_r);
    num_w    = 33'(tw_r) - 33'(tl_r);
    num_mag  = num_w[32] ? 33'(-num_w) : num_w;
    dt_w     = 33'(tr_r) - 33'(tl_r);
    dt_mag   = dt_w[32] ? 33'(-dt_w) : dt_w;
    more_pts = ((CW'(idx_r) + CW'(1)) < count_r);
    diff_w   = 33'(qr_r) - 33'(ql_r);
    mul_w    = PW'(diff_w) * signed'(PW'(alpha_r));
    sh_w     = prod_r >>> FRAC_BITS;
    sum_w    = sh_w + PW'(ql_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (start) state_nxt = S_CMD;
      S_CMD: begin
        if (cmd_r == CMD_QUERY && count_r >= CW'(2)) state_nxt = S_RD_FIRST;
        else state_nxt = S_OUT;
      end
      S_RD_FIRST: state_nxt = S_RD_LAST;
      S_RD_LAST:  state_nxt = (per_w <= 0) ? S_OUT : S_REM;
      S_REM:      if (div_done) state_nxt = S_SRCH_RD;
      S_SRCH_RD:  state_nxt = more_pts ? S_SRCH_CMP : S_LASTQ;
      S_SRCH_CMP: state_nxt = (signed'(t_rdata) < tw_r) ? S_SRCH_RD : S_QL;
      S_LASTQ:    state_nxt = S_OUT;
      S_QL:       state_nxt = S_QR;
      S_QR: begin
        if (dt_w == 0) state_nxt = S_OUT;
        else if (num_w == 0 || (num_w[32] != dt_w[32])) state_nxt = S_MUL;
        else state_nxt = S_DIV;
      end
      S_DIV:      if (div_done) state_nxt = S_MUL;
      S_MUL:      state_nxt = S_FIN;
      S_FIN:      state_nxt = S_OUT;
      S_OUT:      state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs to memories and divider
  always_comb begin
    wr_en        = 1'b0;
    t_raddr      = '0;
    f_raddr      = AW'(idx_r);
    div_start    = 1'b0;
    div_dividend = DW'(d_mag);
    div_divisor  = per_w;
    unique case (state_r)
      S_CMD: begin
        wr_en   = (cmd_r == CMD_APPEND) && (count_r < CW'(MAX_POINTS));
        t_raddr = '0;
      end
      S_RD_FIRST: t_raddr = AW'(count_r - CW'(1));
      S_RD_LAST:  div_start = (per_w > 0);
      S_SRCH_RD: begin
        t_raddr = AW'(CW'(idx_r) + CW'(1));
        f_raddr = AW'(count_r - CW'(1));
      end
      S_SRCH_CMP: f_raddr = idx_r;
      S_QL:       f_raddr = AW'(CW'(idx_r) + CW'(1));
      S_QR: begin
        div_start    = (dt_w != 0) && (num_w != 0) && (num_w[32] == dt_w[32]);
        div_dividend = DW'(num_mag) << FRAC_BITS;
        div_divisor  = dt_mag;
      end
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    cmd_nxt    = cmd_r;
    t_nxt      = t_r;
    q_nxt      = q_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    t0_nxt     = t0_r;
    tw_nxt     = tw_r;
    tl_nxt     = tl_r;
    tr_nxt     = tr_r;
    ql_nxt     = ql_r;
    qr_nxt     = qr_r;
    period_nxt = period_r;
    neg_nxt    = neg_r;
    alpha_nxt  = alpha_r;
    prod_nxt   = prod_r;
    val_nxt    = val_r;
    stat_nxt   = stat_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_cmd;
          t_nxt   = in_sample_time;
          q_nxt   = in_flow_value;
        end
      end
      S_CMD: begin
        val_nxt  = '0;
        stat_nxt = STAT_OK;
        case (cmd_r)
          CMD_CLEAR:  count_nxt = '0;
          CMD_APPEND: begin
            if (count_r < CW'(MAX_POINTS)) count_nxt = count_r + CW'(1);
            else stat_nxt = STAT_FULL;
          end
          CMD_QUERY:  if (count_r < CW'(2)) stat_nxt = STAT_FEW;
          default: ;
        endcase
      end
      S_RD_FIRST: t0_nxt = t_rdata;
      S_RD_LAST: begin
        period_nxt = per_w;
        neg_nxt    = d_w[32];
        if (per_w <= 0) stat_nxt = STAT_ZERO_PER;
      end
      S_REM: begin
        if (div_done) begin
          tw_nxt  = twide_w[31:0];
          tl_nxt  = t0_r;
          idx_nxt = '0;
        end
      end
      S_SRCH_CMP: begin
        if (signed'(t_rdata) < tw_r) begin
          idx_nxt = AW'(CW'(idx_r) + CW'(1));
          tl_nxt  = t_rdata;
        end else begin
          tr_nxt = t_rdata;
        end
      end
      S_LASTQ: val_nxt = f_rdata;
      S_QL:    ql_nxt = f_rdata;
      S_QR: begin
        qr_nxt    = f_rdata;
        alpha_nxt = '0;
        if (dt_w == 0) val_nxt = ql_r;
      end
      S_DIV: begin
        if (div_done) alpha_nxt = (div_quo > DW'(SCALE)) ? SCALE : div_quo[AL-1:0];
      end
      S_MUL: prod_nxt = mul_w + PW'(SCALE >> 1);
      S_FIN: begin
        // saturate to 32 bit signed
        if (sum_w > PW'(32'sh7fffffff)) val_nxt = 32'sh7fffffff;
        else if (sum_w < -PW'(33'sh080000000)) val_nxt = 32'sh80000000;
        else val_nxt = sum_w[31:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    cmd_r    <= cmd_nxt;
    t_r      <= t_nxt;
    q_r      <= q_nxt;
    idx_r    <= idx_nxt;
    t0_r     <= t0_nxt;
    tw_r     <= tw_nxt;
    tl_r     <= tl_nxt;
    tr_r     <= tr_nxt;
    ql_r     <= ql_nxt;
    qr_r     <= qr_nxt;
    period_r <= period_nxt;
    neg_r    <= neg_nxt;
    alpha_r  <= alpha_nxt;
    prod_r   <= prod_nxt;
    val_r    <= val_nxt;
    stat_r   <= stat_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = (state_r == S_OUT);
  assign out_interp_value = val_r;
  assign out_status       = stat_r;

endmodule

// ----- rtl/core/pti_checker.sv -----
// port level checks for the periodic table interpolator
module pti_checker
  import pti_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [DATA_W-1:0] out_interp_value,
  input logic [1:0]        out_status
);

  // an accepted request keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_result_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a busy period");

  a_result_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!busy && !out_valid))
    else $error("block stayed busy after its result");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |-> (out_interp_value == '0))
    else $error("error result carries a nonzero value");

endmodule

bind periodic_table_interpolator pti_checker u_pti_checker (.*);

// ----- test/tb_top.sv -----
// testbench for the periodic table interpolator: queued driver, predictor and result monitor
`timescale 1ns / 1ps
module tb_top
  import pti_pkg::*;
();

  typedef struct {
    logic [1:0]         cmd;
    logic signed [31:0] t;
    logic signed [31:0] f;
  } request_t;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         status;
  } flow_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_cmd = CMD_CLEAR;
  logic signed [31:0] in_sample_time = '0;
  logic signed [31:0] in_flow_value = '0;
  logic out_valid;
  logic signed [31:0] out_interp_value;
  logic [1:0] out_status;

  request_t     pending_reqs[$];
  flow_result_t expected_flows[$];
  request_t     cur_req;
  int           sent_count = 0;
  int           total_reqs = 0;
  int           err_count = 0;

  // predictor state
  logic signed [31:0] bp_time[MAX_POINTS_DEF];
  logic signed [31:0] bp_flow[MAX_POINTS_DEF];
  int                 bp_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  periodic_table_interpolator DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_sample_time(in_sample_time), .in_flow_value(in_flow_value),
    .out_valid(out_valid), .out_interp_value(out_interp_value), .out_status(out_status)
  );

  function automatic longint floor_div(longint num, longint den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic flow_result_t interpolate(longint t);
    flow_result_t r;
    longint t0, period, rem, tw, tl, tr, ql, qr, dt, alpha, scale, prod, v;
    int i;
    r.value = '0;
    r.status = STAT_OK;
    if (bp_count < 2) begin
      r.status = STAT_FEW;
      return r;
    end
    t0 = bp_time[0];
    period = longint'(bp_time[bp_count-1]) - t0;
    if (period <= 0) begin
      r.status = STAT_ZERO_PER;
      return r;
    end
    rem = (t - t0) % period;
    if (rem < 0) rem += period;
    tw = rem + t0;
    i = 0;
    while (i + 1 < bp_count && longint'(bp_time[i+1]) < tw) i++;
    if (i + 1 >= bp_count) begin
      r.value = bp_flow[bp_count-1];
      return r;
    end
    tl = bp_time[i];
    tr = bp_time[i+1];
    ql = bp_flow[i];
    qr = bp_flow[i+1];
    dt = tr - tl;
    if (dt == 0) begin
      r.value = bp_flow[i];
      return r;
    end
    scale = 64'sd1 << FRAC_BITS_DEF;
    alpha = ((tw - tl) * scale) / dt;
    if (alpha < 0) alpha = 0;
    if (alpha > scale) alpha = scale;
    prod = (qr - ql) * alpha + scale / 2;
    v = ql + floor_div(prod, scale);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    r.value = v[31:0];
    return r;
  endfunction

  function automatic flow_result_t apply_request(request_t rq);
    flow_result_t r;
    r.value = '0;
    r.status = STAT_OK;
    case (rq.cmd)
      CMD_CLEAR: bp_count = 0;
      CMD_APPEND: begin
        if (bp_count < MAX_POINTS_DEF) begin
          bp_time[bp_count] = rq.t;
          bp_flow[bp_count] = rq.f;
          bp_count++;
        end else begin
          r.status = STAT_FULL;
        end
      end
      CMD_QUERY: r = interpolate(longint'(rq.t));
      default: ;
    endcase
    return r;
  endfunction

  function automatic int idle_percent();
    if (sent_count < total_reqs / 3) return 21;
    if (sent_count < 2 * total_reqs / 3) return 63;
    return 0;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_flows.insert(expected_flows.size(), apply_request(cur_req));
      if (!start || !busy) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_percent()) begin
          cur_req = pending_reqs.pop_front();
          sent_count++;
          start <= 1'b1;
          in_cmd <= cur_req.cmd;
          in_sample_time <= cur_req.t;
          in_flow_value <= cur_req.f;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    flow_result_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_flows.size() == 0) begin
        $error("unexpected result value=%0d status=%0d", out_interp_value, out_status);
        err_count++;
      end else begin
        exp_r = expected_flows.pop_front();
        if (out_interp_value !== exp_r.value) begin
          $error("interp_value expected %0d actual %0d", exp_r.value, out_interp_value);
          err_count++;
        end
        if (out_status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_status);
          err_count++;
        end
      end
    end
  end

  task automatic add_req(logic [1:0] c, logic signed [31:0] t, logic signed [31:0] f);
    request_t rq;
    rq.cmd = c;
    rq.t = t;
    rq.f = f;
    pending_reqs.insert(pending_reqs.size(), rq);
  endtask

  task automatic add_random_table(int n);
    int tq[$];
    int k;
    for (k = 0; k < n; k++) tq.insert(tq.size(), int'($urandom()));
    if ($urandom_range(9) != 0) tq.sort();
    if ($urandom_range(4) == 0 && n > 2) tq[1] = tq[0];
    add_req(CMD_CLEAR, $urandom(), $urandom());
    for (k = 0; k < n; k++) add_req(CMD_APPEND, tq[k], $urandom());
  endtask

  initial begin
    int k, n, nq;
    // directed: empty, single point, zero period, extremes, equal times, unordered, full
    add_req(CMD_QUERY, 32'sd0, 32'sd0);
    add_req(CMD_APPEND, 32'sh8000_0000, 32'sh7fff_ffff);
    add_req(CMD_QUERY, 32'sh7fff_ffff, 32'sd0);
    add_req(CMD_APPEND, 32'sh8000_0000, 32'sh8000_0000);
    add_req(CMD_QUERY, 32'sd5, 32'sd0);
    add_req(CMD_CLEAR, 32'sh7fff_ffff, 32'sh7fff_ffff);
    add_req(CMD_APPEND, 32'sh8000_0000, 32'sh7fff_ffff);
    add_req(CMD_APPEND, 32'sd0, 32'sd0);
    add_req(CMD_APPEND, 32'sd0, 32'sh8000_0000);
    add_req(CMD_APPEND, 32'sh7fff_ffff, 32'sh8000_0000);
    add_req(CMD_QUERY, 32'sh8000_0000, 32'sd0);
    add_req(CMD_QUERY, 32'sh7fff_ffff, 32'sd0);
    add_req(CMD_QUERY, 32'sd0, 32'sd0);
    add_req(CMD_QUERY, 32'sh4000_0000, 32'sd0);
    add_req(CMD_QUERY, 32'shc000_0000, 32'sd0);
    add_req(2'd3, 32'sh7fff_ffff, 32'sh7fff_ffff);
    add_req(CMD_CLEAR, 32'sd0, 32'sd0);
    add_req(CMD_APPEND, 32'sd100, 32'sd7);
    add_req(CMD_APPEND, 32'sd500, 32'sd9);
    add_req(CMD_APPEND, 32'sd50, 32'sd11);
    add_req(CMD_APPEND, 32'sd600, 32'sd13);
    add_req(CMD_QUERY, 32'sd560, 32'sd0);
    add_req(CMD_QUERY, 32'sd90, 32'sd0);
    // fill to capacity, then overflow and a deep search
    add_req(CMD_CLEAR, 32'sd0, 32'sd0);
    for (k = 0; k < MAX_POINTS_DEF; k++) add_req(CMD_APPEND, k * 4096, $urandom());
    add_req(CMD_APPEND, 32'sd1, 32'sd1);
    add_req(CMD_QUERY, 32'sh7fff_fff0, 32'sd0);
    add_req(CMD_QUERY, -32'sd1, 32'sd0);
    // random: mostly small tables with many queries, a little noise
    while (pending_reqs.size() < 400) begin
      n = ($urandom_range(15) == 0) ? $urandom_range(1, 2) : $urandom_range(2, 10);
      add_random_table(n);
      nq = $urandom_range(3, 10);
      for (k = 0; k < nq; k++) begin
        case ($urandom_range(19))
          0: add_req(2'd3, $urandom(), $urandom());
          1: add_req(CMD_APPEND, $urandom(), $urandom());
          default: add_req(CMD_QUERY, $urandom(), $urandom());
        endcase
      end
    end
    total_reqs = pending_reqs.size();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_reqs.size() != 0 || start || expected_flows.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
